// File: design/iidl_pkg.sv
// Shared constants and types for the indexed insert/delete list.
package iidl_pkg;

    localparam int CAPACITY_DEF = 64;
    localparam int MODE_W       = 3;
    localparam int INDEX_W      = 7;
    localparam int DATA_W       = 32;
    localparam int STATUS_W     = 2;
    localparam int COUNT_W      = 7;

    typedef enum logic [MODE_W-1:0] {
        MODE_GET      = 3'd0,
        MODE_INS_HEAD = 3'd1,
        MODE_APPEND   = 3'd2,
        MODE_INS_AT   = 3'd3,
        MODE_DELETE   = 3'd4
    } t_mode;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE      = 2'd0,
        ST_BAD_INDEX = 2'd1,
        ST_FULL      = 2'd2
    } t_status;

    typedef struct packed {
        logic ins;
        logic del;
        logic get;
    } t_cmd;

endpackage

// File: design/iidl_cell.sv
// One storage cell of the list: holds one entry, shifts to/from its neighbors.
module iidl_cell
    import iidl_pkg::*;
#(
    parameter int POS   = 0,
    parameter int POS_W = 8
) (
    input  logic              i_clk,
    input  t_cmd              i_cmd,
    input  logic [POS_W-1:0]  i_pos,
    input  logic [DATA_W-1:0] i_new,
    input  logic [DATA_W-1:0] i_left,
    input  logic [DATA_W-1:0] i_right,
    output logic [DATA_W-1:0] o_val,
    output logic [DATA_W-1:0] o_rd
);

    localparam logic [POS_W-1:0] MY_POS = POS_W'(POS);

    logic [DATA_W-1:0] r_val;
    logic [DATA_W-1:0] n_val;

    always_comb begin
        n_val = r_val;
        priority if (i_cmd.ins && i_pos == MY_POS) begin
            n_val = i_new;
        end else if (i_cmd.ins && i_pos < MY_POS) begin
            n_val = i_left;
        end else if (i_cmd.del && i_pos <= MY_POS) begin
            n_val = i_right;
        end else begin
            n_val = r_val;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

    assign o_val = r_val;
    assign o_rd  = (i_cmd.get && i_pos == MY_POS) ? r_val : '0;

endmodule

// File: design/indexed_insert_delete_list_top.sv
// Top level of the indexed insert/delete list: a chain of shifting cells.
// The result strobe rises in the cycle after the item is taken; one item per cycle.
// All entries shift in parallel through the cell chain, so busy stays low.
// Reset (synchronous, active low) empties the list and clears the strobe.
// The receiver cannot stall; each result shows for one cycle only.
module indexed_insert_delete_list_top
    import iidl_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [MODE_W-1:0]   i_mode,
    input  logic [INDEX_W-1:0]  i_index,
    input  logic [DATA_W-1:0]   i_value,
    output logic                o_valid,
    output logic [DATA_W-1:0]   o_read_value,
    output logic [STATUS_W-1:0] o_status,
    output logic [COUNT_W-1:0]  o_count
);

    localparam int LEN_W = $clog2(CAPACITY + 1);
    localparam int POS_W = (LEN_W > INDEX_W) ? LEN_W : INDEX_W;
    localparam logic [POS_W-1:0] CAP_P = POS_W'(CAPACITY);

    logic [LEN_W-1:0]    r_len;
    logic [LEN_W-1:0]    n_len;
    logic                r_valid;
    logic [DATA_W-1:0]   r_rd;
    logic [DATA_W-1:0]   n_rd;
    t_status             r_st;
    t_status             n_st;

    logic [POS_W-1:0]    w_len;
    logic [POS_W-1:0]    w_idx;
    logic [POS_W-1:0]    w_pos;
    t_cmd                w_cmd;
    logic                w_take;
    logic [DATA_W-1:0]   w_val [CAPACITY];
    logic [DATA_W-1:0]   w_rd  [CAPACITY];
    logic [DATA_W-1:0]   w_rd_or;

    assign busy   = 1'b0;
    assign w_take = start && !busy;
    assign w_len  = POS_W'(r_len);
    assign w_idx  = POS_W'(i_index);

    always_comb begin
        w_cmd = '0;
        w_pos = w_idx;
        n_st  = ST_BAD_INDEX;
        n_len = r_len;
        unique case (i_mode)
            MODE_GET: begin
                w_cmd.get = w_take;
                if (w_idx < w_len) begin
                    n_st = ST_DONE;
                end
            end
            MODE_INS_HEAD, MODE_APPEND, MODE_INS_AT: begin
                priority case (i_mode)
                    MODE_INS_HEAD: w_pos = '0;
                    MODE_APPEND:   w_pos = w_len;
                    default:       w_pos = w_idx;
                endcase
                priority if (w_pos > w_len) begin
                    n_st = ST_BAD_INDEX;
                end else if (w_len >= CAP_P) begin
                    n_st = ST_FULL;
                end else begin
                    n_st      = ST_DONE;
                    w_cmd.ins = w_take;
                    n_len     = r_len + LEN_W'(1);
                end
            end
            MODE_DELETE: begin
                if (w_idx < w_len) begin
                    n_st      = ST_DONE;
                    w_cmd.del = w_take;
                    n_len     = r_len - LEN_W'(1);
                end
            end
            default: begin
                n_st = ST_BAD_INDEX;
            end
        endcase
    end

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [DATA_W-1:0] w_left;
        logic [DATA_W-1:0] w_right;
        if (g == 0) begin : g_first
            assign w_left = i_value;
        end else begin : g_mid_l
            assign w_left = w_val[g-1];
        end
        if (g == CAPACITY - 1) begin : g_last
            assign w_right = '0;
        end else begin : g_mid_r
            assign w_right = w_val[g+1];
        end
        iidl_cell #(
            .POS   (g),
            .POS_W (POS_W)
        ) u_cell (
            .i_clk   (i_clk),
            .i_cmd   (w_cmd),
            .i_pos   (w_pos),
            .i_new   (i_value),
            .i_left  (w_left),
            .i_right (w_right),
            .o_val   (w_val[g]),
            .o_rd    (w_rd[g])
        );
    end

    always_comb begin
        w_rd_or = '0;
        for (int k = 0; k < CAPACITY; k++) begin
            w_rd_or = w_rd_or | w_rd[k];
        end
    end

    always_comb begin
        n_rd = '1;
        if (i_mode == MODE_GET && n_st == ST_DONE) begin
            n_rd = w_rd_or;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= w_take;
            if (w_take) begin
                r_len <= n_len;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_rd <= n_rd;
            r_st <= n_st;
        end
    end

    assign o_valid      = r_valid;
    assign o_read_value = r_rd;
    assign o_status     = r_st;
    assign o_count      = COUNT_W'(r_len);

endmodule
